[sv/btre_pkg.sv]
// ============================================================================
// btre_pkg
// Types, constants and reset tables shared by the typematic repeat engine.
// ============================================================================
`default_nettype none

package btre_pkg;

    localparam int NUM_ENTRIES   = 12;
    localparam int TIME_BITS     = 32;
    localparam int SKIPPED_ENTRY = 9;

    localparam int ENTRY_W   = 4;
    localparam int BUTTONS_W = 12;
    localparam int KEY_W     = 8;
    localparam int DELAY_W   = 16;
    localparam int RATE_W    = 16;
    localparam int NOW_W     = 32;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 16;

    localparam int OFF_BUTTONS   = 0;
    localparam int OFF_NOW       = OFF_BUTTONS + BUTTONS_W;
    localparam int OFF_CONNECTED = OFF_NOW + NOW_W;
    localparam int OFF_SUPPRESS  = OFF_CONNECTED + 1;
    localparam int OFF_INDEX     = OFF_SUPPRESS + 1;
    localparam int OFF_KEY       = OFF_INDEX + ENTRY_W;
    localparam int OFF_DELAY     = OFF_KEY + KEY_W;
    localparam int OFF_RATE      = OFF_DELAY + DELAY_W;

    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [DELAY_W-1:0] DPAD_DELAY = DELAY_W'(200);
    localparam logic [RATE_W-1:0]  DPAD_RATE  = RATE_W'(50);
    localparam int DPAD_FIRST = 4;
    localparam int DPAD_LAST  = 7;

    localparam logic [KEY_W-1:0] DEFAULT_KEYS [16] = '{
        8'd13, 8'd27, 8'd105, 8'd101, 8'd56, 8'd50, 8'd52, 8'd54,
        8'd27, 8'd77, 8'd82, 8'd115, 8'd0, 8'd0, 8'd0, 8'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                 held;
        logic [TIME_BITS-1:0] press;
        logic [TIME_BITS-1:0] rep;
    } entry_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DELAY_W-1:0] delay;
        logic [RATE_W-1:0]  rate;
    } entry_cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ENTRY_W-1:0] entry;
        logic               rep;
    } result_t;

    typedef struct packed {
        logic st_we;
        logic emit;
        logic rep;
    } eval_ctl_t;

    function automatic entry_cfg_t default_cfg(input logic [ENTRY_W-1:0] idx);
        entry_cfg_t c;
        c.key = DEFAULT_KEYS[idx];
        if (int'(idx) >= DPAD_FIRST && int'(idx) <= DPAD_LAST) begin
            c.delay = DPAD_DELAY;
            c.rate  = DPAD_RATE;
        end else begin
            c.delay = '0;
            c.rate  = '0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/button_typematic_repeat_engine_top.sv]
// ============================================================================
// button_typematic_repeat_engine_top
// Typematic key repeat for a pad of mapped buttons, state held in memories.
// ============================================================================
// The slave channel takes one request at a time: a poll (tuser low) with a
// pressed mask and a millisecond time, or a mapping write (tuser high).
// A write is applied at its accept edge and produces nothing; s_tready stays
// high, so the next request can be taken on the next cycle. A poll that is
// disconnected or suppressed is likewise consumed with no walk. An active
// poll walks the entries one per cycle while the master side does not stall
// it, through a single read port of the state and mapping memories, skipping
// the unused entry. A poll occupies the block from its accept through the
// walk over the visited entries and a flush state; master side stalls
// lengthen this. Each key found is held one entry back so the last one of
// the poll can carry tlast. A key is offered on the master side after the
// next emitting entry is found or after the walk ends; the last key of a
// poll is offered from the flush state. When m_tready is low, the walk
// pauses at the next entry that needs to emit, without loss.
// Reset clears the per-entry valid bits at once, so held flags and stamps
// read as zero and the mappings read as their defaults; the block is ready
// in the first cycle after reset.
// ============================================================================
`default_nettype none

module button_typematic_repeat_engine_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // buttons, now_ms, connected, suppress, entry_index, new_key, new_delay,
    // new_rate, zero fill
    input  wire logic [btre_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // key_out, source_entry, zero fill
    output logic [btre_pkg::M_DATA_W-1:0]      m_tdata,
    // is_repeat
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam logic [btre_pkg::ENTRY_W-1:0] FIRST_IDX =
        (btre_pkg::SKIPPED_ENTRY == 0) ? btre_pkg::ENTRY_W'(1) : '0;
    localparam logic FIRST_OK = (int'(FIRST_IDX) < btre_pkg::NUM_ENTRIES);

    btre_pkg::entry_state_t st_mem  [btre_pkg::NUM_ENTRIES];
    btre_pkg::entry_cfg_t   cfg_mem [btre_pkg::NUM_ENTRIES];

    btre_pkg::state_t                    state_reg, state_next;
    logic [btre_pkg::ENTRY_W-1:0]        idx_reg, idx_next;
    logic [btre_pkg::BUTTONS_W-1:0]      buttons_reg, buttons_next;
    logic [btre_pkg::TIME_BITS-1:0]      now_reg, now_next;
    logic [btre_pkg::NUM_ENTRIES-1:0]    st_vld_reg, st_vld_next;
    logic [btre_pkg::NUM_ENTRIES-1:0]    cfg_vld_reg, cfg_vld_next;
    logic                                pend_valid_reg, pend_valid_next;
    btre_pkg::result_t                   pend_reg, pend_next;
    logic                                out_valid_reg, out_valid_next;
    btre_pkg::result_t                   out_reg, out_next;
    logic                                out_last_reg, out_last_next;

    btre_pkg::entry_state_t              st_rd_reg;
    btre_pkg::entry_cfg_t                cfg_rd_reg;
    logic                                st_rvld_reg;
    logic                                cfg_rvld_reg;

    logic [btre_pkg::ENTRY_W-1:0]        rd_addr;
    logic                                st_we;
    logic                                cfg_we;
    logic [btre_pkg::ENTRY_W-1:0]        cfg_waddr;
    btre_pkg::entry_cfg_t                cfg_wdata;

    btre_pkg::entry_state_t              cur_st;
    btre_pkg::entry_cfg_t                cur_cfg;
    btre_pkg::entry_state_t              new_st;
    btre_pkg::eval_ctl_t                 ctl;
    logic [15:0]                         btn_ext;
    logic                                pressed;
    logic [btre_pkg::ENTRY_W:0]          step1;
    logic [btre_pkg::ENTRY_W:0]          step_idx;
    logic                                step_ok;
    logic                                s_acc;
    logic                                out_free;
    logic                                proceed;
    logic                                poll_active;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == btre_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign cfg_waddr       = s_tdata[btre_pkg::OFF_INDEX +: btre_pkg::ENTRY_W];
    assign cfg_wdata.key   = s_tdata[btre_pkg::OFF_KEY +: btre_pkg::KEY_W];
    assign cfg_wdata.delay = s_tdata[btre_pkg::OFF_DELAY +: btre_pkg::DELAY_W];
    assign cfg_wdata.rate  = s_tdata[btre_pkg::OFF_RATE +: btre_pkg::RATE_W];
    assign cfg_we = s_acc && (s_tuser == btre_pkg::OP_WRITE) &&
                    (int'(cfg_waddr) < btre_pkg::NUM_ENTRIES);

    assign poll_active = s_tdata[btre_pkg::OFF_CONNECTED] &&
                         !s_tdata[btre_pkg::OFF_SUPPRESS];

    assign cur_st  = st_rvld_reg ? st_rd_reg : '0;
    assign cur_cfg = cfg_rvld_reg ? cfg_rd_reg : btre_pkg::default_cfg(idx_reg);
    assign btn_ext = 16'(buttons_reg);
    assign pressed = btn_ext[idx_reg];

    assign step1    = {1'b0, idx_reg} + 1'b1;
    assign step_idx = (int'(step1) == btre_pkg::SKIPPED_ENTRY) ? step1 + 1'b1 : step1;
    assign step_ok  = (int'(step_idx) < btre_pkg::NUM_ENTRIES);

    assign proceed = !ctl.emit || !pend_valid_reg || out_free;
    assign st_we   = (state_reg == btre_pkg::ST_SCAN) && proceed && ctl.st_we;

    btre_eval u_eval (
        .pressed (pressed),
        .now     (now_reg),
        .st_in   (cur_st),
        .cfg_in  (cur_cfg),
        .st_out  (new_st),
        .ctl     (ctl)
    );

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        buttons_next    = buttons_reg;
        now_next        = now_reg;
        st_vld_next     = st_vld_reg;
        cfg_vld_next    = cfg_vld_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        rd_addr         = idx_reg;

        case (state_reg)
            btre_pkg::ST_IDLE: begin
                rd_addr = FIRST_IDX;
                if (cfg_we) begin
                    cfg_vld_next[cfg_waddr] = 1'b1;
                end
                if (s_acc && s_tuser == btre_pkg::OP_POLL && poll_active && FIRST_OK) begin
                    buttons_next = s_tdata[btre_pkg::OFF_BUTTONS +: btre_pkg::BUTTONS_W];
                    now_next     = s_tdata[btre_pkg::OFF_NOW +: btre_pkg::TIME_BITS];
                    idx_next     = FIRST_IDX;
                    state_next   = btre_pkg::ST_SCAN;
                end
            end
            btre_pkg::ST_SCAN: begin
                if (proceed) begin
                    if (ctl.st_we) begin
                        st_vld_next[idx_reg] = 1'b1;
                    end
                    if (ctl.emit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next.key   = cur_cfg.key;
                        pend_next.entry = idx_reg;
                        pend_next.rep   = ctl.rep;
                    end
                    if (step_ok) begin
                        idx_next = step_idx[btre_pkg::ENTRY_W-1:0];
                        rd_addr  = step_idx[btre_pkg::ENTRY_W-1:0];
                    end else begin
                        state_next = btre_pkg::ST_FLUSH;
                    end
                end
            end
            btre_pkg::ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = btre_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = btre_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = btre_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= btre_pkg::ST_IDLE;
            st_vld_reg     <= '0;
            cfg_vld_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            st_vld_reg     <= st_vld_next;
            cfg_vld_reg    <= cfg_vld_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        buttons_reg  <= buttons_next;
        now_reg      <= now_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        st_rvld_reg  <= st_vld_reg[rd_addr];
        cfg_rvld_reg <= cfg_vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[idx_reg] <= new_st;
        end
        st_rd_reg <= st_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cfg_we) begin
            cfg_mem[cfg_waddr] <= cfg_wdata;
        end
        cfg_rd_reg <= cfg_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = btre_pkg::M_DATA_W'({out_reg.entry, out_reg.key});
    assign m_tuser  = out_reg.rep;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[sv/btre_eval.sv]
// ============================================================================
// btre_eval
// Per-entry decision: press edge, release, or timed auto repeat.
// ============================================================================
`default_nettype none

module btre_eval (
    input  wire logic                           pressed,
    input  wire logic [btre_pkg::TIME_BITS-1:0] now,
    input  wire btre_pkg::entry_state_t         st_in,
    input  wire btre_pkg::entry_cfg_t           cfg_in,
    output btre_pkg::entry_state_t              st_out,
    output btre_pkg::eval_ctl_t                 ctl
);

    logic [btre_pkg::TIME_BITS-1:0] since_press;
    logic [btre_pkg::TIME_BITS-1:0] since_rep;
    logic                           timer_due;

    assign since_press = now - st_in.press;
    assign since_rep   = now - st_in.rep;
    assign timer_due   = (since_press >= btre_pkg::TIME_BITS'(cfg_in.delay)) &&
                         (since_rep >= btre_pkg::TIME_BITS'(cfg_in.rate));

    always_comb begin
        st_out = st_in;
        ctl    = '0;
        if (pressed && !st_in.held) begin
            st_out.held  = 1'b1;
            st_out.press = now;
            st_out.rep   = now;
            ctl.st_we    = 1'b1;
            ctl.emit     = 1'b1;
        end else if (!pressed && st_in.held) begin
            st_out    = '0;
            ctl.st_we = 1'b1;
        end else if (pressed && st_in.held && cfg_in.rate != '0 && timer_due) begin
            st_out.rep = now;
            ctl.st_we  = 1'b1;
            ctl.emit   = 1'b1;
            ctl.rep    = 1'b1;
        end
    end

endmodule

`default_nettype wire
